FILE: design/assert_macros.svh
// Assertion helpers, sampled on the rising clock edge and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold at every edge
`define ASSERT_ALWAYS(label, clk, rst_n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cons)) \
    else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/u2u_pkg.sv
package u2u_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned UNIT_W = 16;
  localparam int unsigned LEFT_W = 3;
  localparam int unsigned CONT_BITS = 6;

  localparam logic [1:0] CONT_TAG = 2'b10;
  localparam logic [4:0] SURR_TAG = 5'b11011;

  typedef struct packed {
    logic [LEFT_W-1:0] bytes_left;
    logic [UNIT_W-1:0] partial;
    logic              partial_hi;
    logic              broken;
    logic              draining;
  } dec_state_t;

  typedef struct packed {
    logic              fire;
    logic [UNIT_W-1:0] code_unit;
    logic              unit_valid;
    logic              string_end;
  } dec_result_t;

  localparam dec_state_t STATE_CLEAR = '0;

endpackage

FILE: design/u2u_step.sv
module u2u_step
  import u2u_pkg::*;
(
  input  dec_state_t        st,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              buffer_end,
  output dec_state_t        st_nxt,
  output dec_result_t       res
);

  logic              lead_ok;
  logic [LEFT_W-1:0] lead_left;
  logic [UNIT_W-1:0] lead_first;
  logic              cont_bad;
  logic              broken_c;
  logic [UNIT_W-1:0] partial_c;
  logic              hi_c;
  logic [LEFT_W-1:0] left_c;
  logic              unit_ok;

  always_comb begin
    lead_ok    = 1'b1;
    lead_left  = '0;
    lead_first = '0;
    case (in_byte) inside
      8'b110?????: begin
        lead_left  = LEFT_W'(1);
        lead_first = UNIT_W'(in_byte[4:0]);
      end
      8'b1110????: begin
        lead_left  = LEFT_W'(2);
        lead_first = UNIT_W'(in_byte[3:0]);
      end
      8'b11110???: begin
        lead_left  = LEFT_W'(3);
        lead_first = UNIT_W'(in_byte[2:0]);
      end
      8'b111110??: begin
        lead_left  = LEFT_W'(4);
        lead_first = UNIT_W'(in_byte[1:0]);
      end
      8'b1111110?: begin
        lead_left  = LEFT_W'(5);
        lead_first = UNIT_W'(in_byte[0]);
      end
      default: lead_ok = 1'b0;
    endcase
  end

  // continuation byte
  assign cont_bad  = (in_byte[7:6] != CONT_TAG);
  assign broken_c  = st.broken | cont_bad;
  assign partial_c = cont_bad ? st.partial
                              : {st.partial[UNIT_W-CONT_BITS-1:0], in_byte[CONT_BITS-1:0]};
  assign hi_c      = st.partial_hi | (!cont_bad && (st.partial[UNIT_W-1:UNIT_W-CONT_BITS] != '0));
  assign left_c    = st.bytes_left - LEFT_W'(1);
  assign unit_ok   = !broken_c && !hi_c && (partial_c[15:11] != SURR_TAG);

  always_comb begin
    st_nxt = st;
    res    = '0;
    if (st.draining) begin
      if (buffer_end) begin
        st_nxt = STATE_CLEAR;
      end
    end else if (st.bytes_left == '0) begin
      if (in_byte == '0) begin
        st_nxt          = STATE_CLEAR;
        st_nxt.draining = !buffer_end;
        res.fire        = 1'b1;
        res.string_end  = 1'b1;
      end else if (!in_byte[7]) begin
        if (buffer_end) begin
          st_nxt = STATE_CLEAR;
        end
        res.fire       = 1'b1;
        res.unit_valid = 1'b1;
        res.code_unit  = UNIT_W'(in_byte);
        res.string_end = buffer_end;
      end else if (buffer_end) begin
        st_nxt         = STATE_CLEAR;
        res.fire       = 1'b1;
        res.string_end = 1'b1;
      end else if (lead_ok) begin
        st_nxt.bytes_left = lead_left;
        st_nxt.partial    = lead_first;
        st_nxt.partial_hi = 1'b0;
        st_nxt.broken     = 1'b0;
      end
    end else if (left_c == '0) begin
      st_nxt         = STATE_CLEAR;
      res.fire       = unit_ok | buffer_end;
      res.unit_valid = unit_ok;
      res.code_unit  = unit_ok ? partial_c : '0;
      res.string_end = buffer_end;
    end else if (buffer_end) begin
      st_nxt         = STATE_CLEAR;
      res.fire       = 1'b1;
      res.string_end = 1'b1;
    end else begin
      st_nxt.bytes_left = left_c;
      st_nxt.partial    = partial_c;
      st_nxt.partial_hi = hi_c;
      st_nxt.broken     = broken_c;
    end
  end

endmodule

FILE: design/utf8_to_ucs2_converter_core.sv
// The result of an input transfer appears in the output register in the next cycle.
// Throughput: one byte per cycle while in_tready is high; the decode state updates in the accepting cycle.
// in_tready stays high while the output register is empty or being drained.
// Reset (rst_n low, synchronous): decode state cleared, output register empty.
`include "assert_macros.svh"

module utf8_to_ucs2_converter_core
  import u2u_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] in_byte
  input  logic              in_tlast,   // buffer_end
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [UNIT_W-1:0] out_tdata,  // [15:0] code_unit
  output logic              out_tuser,  // [0] unit_valid
  output logic              out_tlast   // string_end
);

  dec_state_t  st_r, st_nxt;
  dec_result_t res;
  logic        in_xfer;

  logic              out_valid_r;
  logic [UNIT_W-1:0] out_unit_r;
  logic              out_uvalid_r;
  logic              out_end_r;

  u2u_step u_step (
    .st        (st_r),
    .in_byte   (in_tdata),
    .buffer_end(in_tlast),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= STATE_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        st_r        <= st_nxt;
        out_valid_r <= res.fire;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res.fire) begin
      out_unit_r   <= res.code_unit;
      out_uvalid_r <= res.unit_valid;
      out_end_r    <= res.string_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_unit_r;
  assign out_tuser  = out_uvalid_r;
  assign out_tlast  = out_end_r;

  `ASSERT_IMPLY(a_no_surrogate, clk, rst_n, out_tvalid && out_tuser,
    out_tdata[15:11] != SURR_TAG, "surrogate code unit emitted")
  `ASSERT_IMPLY(a_invalid_zero, clk, rst_n, out_tvalid && !out_tuser,
    out_tdata == '0 && out_tlast, "result without unit must be an end marker")
  `ASSERT_ALWAYS(a_drain_boundary, clk, rst_n,
    !st_r.draining || st_r.bytes_left == '0, "draining inside a sequence")
  `ASSERT_NEXT(a_end_clears, clk, rst_n, in_xfer && in_tlast,
    st_r == STATE_CLEAR, "state not cleared after buffer end")

endmodule
